>>> hw/rtl/rsrt_pkg.sv
`timescale 1ns / 1ps

package rsrt_pkg;

   // Default number of shadow entries
   localparam int TABLE_DEPTH_DEF = 32;

   // Result status codes
   localparam logic [2:0] STATUS_APPENDED = 3'd0;
   localparam logic [2:0] STATUS_UPDATED  = 3'd1;
   localparam logic [2:0] STATUS_FULL     = 3'd2;
   localparam logic [2:0] STATUS_REPLAY   = 3'd3;
   localparam logic [2:0] STATUS_EMPTY    = 3'd4;

   // Request kinds
   localparam logic KIND_SAVE   = 1'b0;
   localparam logic KIND_REPLAY = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_RESP,
      ST_REPLAY
   } state_type;

   // Datapath flags seen by the sequencer
   typedef struct packed {
      logic req_fire;
      logic req_kind;
      logic pend;
      logic hit;
      logic scan_end;
      logic full;
      logic count_zero;
      logic out_free;
      logic last_entry;
   } seq_stat_type;

   // Sequencer commands to the datapath
   typedef struct packed {
      logic       req_ready;
      logic       clear_scan;
      logic       rd_en;
      logic       consume;
      logic       wr_hit;
      logic       wr_append;
      logic       status_load;
      logic [2:0] status_code;
      logic       out_load_single;
      logic       out_load_entry;
   } seq_ctrl_type;

endpackage

>>> hw/rtl/rsrt_ram.sv
`timescale 1ns / 1ps

module rsrt_ram #(
   parameter int WIDTH  = 16,
   parameter int DEPTH  = 32,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read, hold when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/rsrt_seq.sv
`timescale 1ns / 1ps

module rsrt_seq
   import rsrt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  seq_stat_type stat,
   output seq_ctrl_type ctrl
);

   state_type state_ff;
   state_type state_in;

   logic hit_now;

   assign hit_now = stat.pend && stat.hit;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (stat.req_fire) begin
               if (stat.req_kind == KIND_SAVE) begin
                  state_in = ST_SEARCH;
               end else if (stat.count_zero) begin
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_REPLAY;
               end
            end
         end
         ST_SEARCH: begin
            if (hit_now || stat.scan_end) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_REPLAY: begin
            if (stat.pend && stat.out_free && stat.last_entry) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Command outputs
   always_comb begin
      ctrl = '0;
      case (state_ff)
         ST_IDLE: begin
            ctrl.req_ready  = 1'b1;
            ctrl.clear_scan = stat.req_fire;
            if (stat.req_fire && stat.req_kind == KIND_REPLAY && stat.count_zero) begin
               ctrl.status_load = 1'b1;
               ctrl.status_code = STATUS_EMPTY;
            end
         end
         ST_SEARCH: begin
            // Compare the entry read last cycle while fetching the next one
            ctrl.consume = 1'b1;
            if (hit_now) begin
               ctrl.wr_hit      = 1'b1;
               ctrl.status_load = 1'b1;
               ctrl.status_code = STATUS_UPDATED;
            end else if (stat.scan_end) begin
               ctrl.wr_append   = !stat.full;
               ctrl.status_load = 1'b1;
               ctrl.status_code = stat.full ? STATUS_FULL : STATUS_APPENDED;
            end else begin
               ctrl.rd_en = 1'b1;
            end
         end
         ST_RESP: begin
            ctrl.out_load_single = stat.out_free;
         end
         ST_REPLAY: begin
            // Stream entries, one per cycle while the output drains
            ctrl.consume        = stat.out_free;
            ctrl.out_load_entry = stat.pend && stat.out_free;
            ctrl.rd_en          = !stat.scan_end && (!stat.pend || stat.out_free);
         end
         default: begin
            ctrl = '0;
         end
      endcase
   end

endmodule

>>> hw/rtl/register_shadow_replay_table_unit.sv
`timescale 1ns / 1ps
// Channel  Direction  Signals
// req      in         req_valid, req_ready, req_kind, req_reg_address, req_reg_value
// rsp      out        rsp_valid, rsp_ready, rsp_status, rsp_send_address, rsp_send_value,
//                     rsp_last
//
// A save scans the stored entries through one RAM read port and one address
// comparator, one entry per cycle. A replay streams one entry per cycle from
// the same read port while the output is free. One request is in work at
// a time. Reset clears the entry count and the sequencer; table contents
// are kept. A stalled result holds in the output register; replay pauses
// its reads.

module register_shadow_replay_table_unit
   import rsrt_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_kind,
   input  logic [7:0] req_reg_address,
   input  logic [7:0] req_reg_value,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_status,
   output logic [7:0] rsp_send_address,
   output logic [7:0] rsp_send_value,
   output logic       rsp_last
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   seq_stat_type stat;
   seq_ctrl_type ctrl;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] issue_idx_ff, issue_idx_in;
   logic [CNT_W-1:0] pend_idx_ff, pend_idx_in;
   logic             pend_ff, pend_in;
   logic [7:0]       sav_addr_ff, sav_addr_in;
   logic [7:0]       sav_val_ff, sav_val_in;
   logic [2:0]       res_status_ff, res_status_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_status_ff, rsp_status_in;
   logic [7:0]       rsp_addr_ff, rsp_addr_in;
   logic [7:0]       rsp_val_ff, rsp_val_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             req_fire;
   logic             out_free;
   logic             last_entry;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [15:0]      rd_data;

   assign req_ready  = ctrl.req_ready;
   assign req_fire   = req_valid && ctrl.req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign last_entry = (CNT_W'(pend_idx_ff + CNT_W'(1)) == count_ff);

   // Flags for the sequencer
   always_comb begin
      stat.req_fire   = req_fire;
      stat.req_kind   = req_kind;
      stat.pend       = pend_ff;
      stat.hit        = (rd_data[15:8] == sav_addr_ff);
      stat.scan_end   = (issue_idx_ff == count_ff);
      stat.full       = (count_ff == CNT_W'(TABLE_DEPTH));
      stat.count_zero = (count_ff == '0);
      stat.out_free   = out_free;
      stat.last_entry = last_entry;
   end

   rsrt_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   // Entry store: address in the upper byte, value in the lower
   assign wr_en   = ctrl.wr_hit || ctrl.wr_append;
   assign wr_addr = ctrl.wr_hit ? pend_idx_ff[IDX_W-1:0] : count_ff[IDX_W-1:0];

   rsrt_ram #(
      .WIDTH (16),
      .DEPTH (TABLE_DEPTH),
      .ADDR_W(IDX_W)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data({sav_addr_ff, sav_val_ff}),
      .rd_en  (ctrl.rd_en),
      .rd_addr(issue_idx_ff[IDX_W-1:0]),
      .rd_data(rd_data)
   );

   // Scan pointers and entry count
   always_comb begin
      count_in     = count_ff;
      issue_idx_in = issue_idx_ff;
      pend_idx_in  = pend_idx_ff;
      pend_in      = ctrl.rd_en || (pend_ff && !ctrl.consume);
      if (ctrl.clear_scan) begin
         issue_idx_in = '0;
         pend_in      = 1'b0;
      end else if (ctrl.rd_en) begin
         issue_idx_in = CNT_W'(issue_idx_ff + CNT_W'(1));
         pend_idx_in  = issue_idx_ff;
      end
      if (ctrl.wr_append) begin
         count_in = CNT_W'(count_ff + CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         issue_idx_ff <= '0;
         pend_ff      <= 1'b0;
      end else begin
         count_ff     <= count_in;
         issue_idx_ff <= issue_idx_in;
         pend_ff      <= pend_in;
      end
   end

   // Hold the save request and pending result code
   always_comb begin
      sav_addr_in   = req_fire ? req_reg_address : sav_addr_ff;
      sav_val_in    = req_fire ? req_reg_value : sav_val_ff;
      res_status_in = ctrl.status_load ? ctrl.status_code : res_status_ff;
   end

   always_ff @(posedge clock) begin
      pend_idx_ff   <= pend_idx_in;
      sav_addr_ff   <= sav_addr_in;
      sav_val_ff    <= sav_val_in;
      res_status_ff <= res_status_in;
   end

   // Output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_val_in    = rsp_val_ff;
      rsp_last_in   = rsp_last_ff;
      if (ctrl.out_load_single) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_addr_in   = '0;
         rsp_val_in    = '0;
         rsp_last_in   = 1'b1;
      end else if (ctrl.out_load_entry) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = STATUS_REPLAY;
         rsp_addr_in   = rd_data[15:8];
         rsp_val_in    = rd_data[7:0];
         rsp_last_in   = last_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_val_ff    <= rsp_val_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_send_address = rsp_addr_ff;
   assign rsp_send_value   = rsp_val_ff;
   assign rsp_last         = rsp_last_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_hit_no_read: assert property (@(posedge clock) disable iff (reset)
      ctrl.wr_hit |-> !ctrl.rd_en)
      else $error("update write overlaps a table read");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (ctrl.out_load_single || ctrl.out_load_entry) |-> out_free)
      else $error("result loaded over an untaken result");

   a_append_count: assert property (@(posedge clock) disable iff (reset)
      ctrl.wr_append |=> count_ff == CNT_W'($past(count_ff) + CNT_W'(1)))
      else $error("append did not advance the entry count");

   a_append_room: assert property (@(posedge clock) disable iff (reset)
      ctrl.wr_append |-> count_ff < CNT_W'(TABLE_DEPTH))
      else $error("append into a full table");

endmodule
